// ===== sv/tbrl_pkg.sv =====
// Shared types and constants for the token bucket rate limiter.
// No dependencies; imported by token_bucket_rate_limiter.
`timescale 1ns / 1ps

package tbrl_pkg;

   // Field widths
   localparam int USER_W   = 8;
   localparam int TIME_W   = 32;
   localparam int TOKEN_W  = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;

   // Defaults
   localparam int NUM_USERS_DEFAULT = 256;
   localparam logic [TOKEN_W-1:0] RST_MAX_TOKENS = 16'd100;
   localparam logic [TOKEN_W-1:0] RST_WINDOW     = 16'd60;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TOKENS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW     = 8'd1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } tbrl_state_type;

endpackage

// ===== sv/token_bucket_rate_limiter.sv =====
// Per-user token bucket policer: bucket memory, refill multiply and divide, FSM.
// Depends on tbrl_pkg.
`timescale 1ns / 1ps

// Sequence: a first request, an out-of-range user or a full refill goes from the read state
// straight to the result strobe; else read, multiply, 16-step restoring divide, then the result.
// A new request is taken only in idle, after the result strobe of the last one.
// busy is high from the accepting edge until the result strobe; the receiver cannot stall.
// Reset (synchronous): clears all seen bits at once and loads max_tokens=100,
// window_seconds=60; bucket memory contents are not cleared.
module token_bucket_rate_limiter
   import tbrl_pkg::*;
#(
   parameter int NUM_USERS = NUM_USERS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 start,
   output logic                 busy,
   input  logic [USER_W-1:0]    req_user_index,
   input  logic [TIME_W-1:0]    req_now_seconds,
   // result
   output logic                 rsp_valid,
   output logic                 rsp_allowed,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int DEPTH  = (NUM_USERS < (1 << USER_W)) ? NUM_USERS : (1 << USER_W);
   localparam int AW     = $clog2(DEPTH);
   localparam int WORD_W = TOKEN_W + TIME_W;
   localparam int CNT_W  = $clog2(TOKEN_W);

   // Config registers
   logic [TOKEN_W-1:0] max_ff, max_in;
   logic [TOKEN_W-1:0] window_ff, window_in;

   // Control
   tbrl_state_type     state_ff, state_in;
   logic [DEPTH-1:0]   seen_ff, seen_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Item payload
   logic [AW-1:0]      idx_ff, idx_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               oor_ff, oor_in;
   logic               first_ff, first_in;
   logic               sat_ff, sat_in;
   logic [TOKEN_W-1:0] tok_ff, tok_in;
   logic [TOKEN_W-1:0] el_ff, el_in;

   // Divider
   logic [TOKEN_W-1:0] rem_ff, rem_in;
   logic [TOKEN_W-1:0] dvd_ff, dvd_in;
   logic [TOKEN_W-1:0] quo_ff, quo_in;

   // Bucket memory: {tokens, last_refill}
   logic [WORD_W-1:0]  mem [DEPTH];
   logic [WORD_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [WORD_W-1:0]  wr_data;

   logic               accept;
   logic               in_range;
   logic [TIME_W-1:0]  elapsed;
   logic               sat_now;
   logic               seen_now;
   logic [2*TOKEN_W-1:0] product;
   logic [TOKEN_W:0]   trial;
   logic               trial_ge;
   logic [TOKEN_W:0]   sum;
   logic [TOKEN_W-1:0] level;
   logic [TOKEN_W-1:0] tok_wr;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign in_range  = 32'(req_user_index) < 32'(NUM_USERS);

   // Read stage: elapsed time and full-refill check
   assign elapsed  = now_ff - rd_data_ff[TIME_W-1:0];
   assign sat_now  = elapsed >= 32'(window_ff);
   assign seen_now = seen_ff[idx_ff];

   // Multiplier: elapsed is below window here, so it fits in 16 bits
   assign product = {{TOKEN_W{1'b0}}, el_ff} * {{TOKEN_W{1'b0}}, max_ff};

   // One restoring divide step
   assign trial    = {rem_ff, dvd_ff[TOKEN_W-1]};
   assign trial_ge = trial >= {1'b0, window_ff};

   // Final level, capped at max_tokens
   assign sum = {1'b0, tok_ff} + {1'b0, quo_ff};
   always_comb begin
      if (first_ff || sat_ff || (sum > {1'b0, max_ff})) begin
         level = max_ff;
      end else begin
         level = sum[TOKEN_W-1:0];
      end
      tok_wr = (level != '0) ? level - 1'b1 : '0;
   end
   assign wr_data = {tok_wr, now_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_READ;
         end
         ST_READ: begin
            if (oor_ff || !seen_now || sat_now) state_in = ST_DONE;
            else state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '1) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      rsp_allowed = 1'b0;
      mem_we      = 1'b0;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_DONE: begin
            rsp_valid   = 1'b1;
            rsp_allowed = !oor_ff && (level != '0);
            mem_we      = !oor_ff;
         end
         default: busy = 1'b1;
      endcase
   end

   // Datapath next values
   always_comb begin
      max_in    = max_ff;
      window_in = window_ff;
      seen_in   = seen_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      now_in    = now_ff;
      oor_in    = oor_ff;
      first_in  = first_ff;
      sat_in    = sat_ff;
      tok_in    = tok_ff;
      el_in     = el_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;

      // config writes; other indexes are ignored
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_MAX_TOKENS) max_in = csr_wdata;
         else if (csr_index == CSR_WINDOW) window_in = csr_wdata;
      end

      if (accept) begin
         idx_in = req_user_index[AW-1:0];
         now_in = req_now_seconds;
         oor_in = !in_range;
      end

      case (state_ff)
         ST_READ: begin
            first_in = !seen_now;
            sat_in   = sat_now;
            tok_in   = rd_data_ff[WORD_W-1:TIME_W];
            el_in    = elapsed[TOKEN_W-1:0];
         end
         ST_MUL: begin
            rem_in = product[2*TOKEN_W-1:TOKEN_W];
            dvd_in = product[TOKEN_W-1:0];
            quo_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            rem_in = trial_ge ? 16'(trial - {1'b0, window_ff}) : trial[TOKEN_W-1:0];
            dvd_in = {dvd_ff[TOKEN_W-2:0], 1'b0};
            quo_in = {quo_ff[TOKEN_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_DONE: begin
            if (!oor_ff) seen_in[idx_ff] = 1'b1;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seen_ff   <= '0;
         max_ff    <= RST_MAX_TOKENS;
         window_ff <= RST_WINDOW;
      end else begin
         state_ff  <= state_in;
         seen_ff   <= seen_in;
         max_ff    <= max_in;
         window_ff <= window_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      now_ff   <= now_in;
      oor_ff   <= oor_in;
      first_ff <= first_in;
      sat_ff   <= sat_in;
      tok_ff   <= tok_in;
      el_ff    <= el_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      quo_ff   <= quo_in;
   end

   // Bucket memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_ff] <= wr_data;
      if (accept) rd_data_ff <= mem[req_user_index[AW-1:0]];
   end

   // Checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted item");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("more than one result strobe for an item");

   a_oor_denied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && oor_ff) |-> (!rsp_allowed && !mem_we))
      else $error("out-of-range user allowed or written");

   a_tokens_below_cap: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((tok_wr < max_ff) || (max_ff == '0)))
      else $error("stored tokens not below capacity");

   a_seen_set: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> seen_ff[$past(idx_ff)])
      else $error("seen bit not set after a bucket write");

endmodule
